>>> rtl/etf_pkg.sv
// Package for the escape-time fractal iterator: job record, formats and register indexes.
// No dependencies; imported by every module of the block but etf_queue.
`timescale 1ns / 1ps
`default_nettype none

package etf_pkg;

  localparam int unsigned CoordWidth    = 32;
  localparam int unsigned CoordFracBits = 28;
  localparam int unsigned MagWidth      = 64;
  localparam int unsigned MagOutWidth   = 63;
  localparam int unsigned LimitWidth    = 16;
  localparam int unsigned CountWidth    = 16;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [MagWidth-1:0] MagFour = 64'd4 << (2 * CoordFracBits);

  localparam logic [CfgIdxWidth-1:0] RegJuliaMode = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegJuliaRe   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegJuliaIm   = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegIterLimit = 2'd3;

  localparam logic [LimitWidth-1:0] IterLimitReset = 16'd256;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] cr;
    logic signed [CoordWidth-1:0] ci;
    logic        [LimitWidth-1:0] limit;
  } etf_job_t;

endpackage

`default_nettype wire

>>> rtl/etf_queue.sv
// Small first-in first-out queue between the front end and the iteration engine.
// Uses nothing but its own parameters.
`timescale 1ns / 1ps
`default_nettype none

module etf_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic      [Width-1:0] pop_data_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/etf_front.sv
// Front end: configuration registers, input stream acceptance and job set-up by mode.
// Depends on etf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module etf_front import etf_pkg::*; #(
  parameter int unsigned CountW = CountWidth
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [63:0]             s_axis_tdata,
  output logic                         job_valid_o,
  input  wire logic                    job_ready_i,
  output etf_job_t                     job_o
);

  localparam logic [31:0] CountMax = 32'((64'd1 << CountW) - 64'd1);

  logic                         julia_mode_q;
  logic signed [CoordWidth-1:0] julia_re_q, julia_im_q;
  logic [LimitWidth-1:0]        iter_limit_q;
  logic signed [CoordWidth-1:0] point_re, point_im;
  logic [LimitWidth-1:0]        limit_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      julia_mode_q <= 1'b0;
      julia_re_q   <= '0;
      julia_im_q   <= '0;
      iter_limit_q <= IterLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegJuliaMode: julia_mode_q <= cfg_data_i[0];
        RegJuliaRe:   julia_re_q   <= cfg_data_i[CoordWidth-1:0];
        RegJuliaIm:   julia_im_q   <= cfg_data_i[CoordWidth-1:0];
        RegIterLimit: iter_limit_q <= cfg_data_i[LimitWidth-1:0];
        default: ;
      endcase
    end
  end

  assign point_re = s_axis_tdata[31:0];
  assign point_im = s_axis_tdata[63:32];

  always_comb begin
    limit_sat = iter_limit_q;
    if (32'(iter_limit_q) > CountMax) begin
      limit_sat = CountMax[LimitWidth-1:0];
    end
    job_o.limit = limit_sat;
    if (julia_mode_q) begin
      job_o.x  = point_re;
      job_o.y  = point_im;
      job_o.cr = julia_re_q;
      job_o.ci = julia_im_q;
    end else begin
      job_o.x  = '0;
      job_o.y  = '0;
      job_o.cr = point_re;
      job_o.ci = point_im;
    end
  end

  assign job_valid_o   = s_axis_tvalid;
  assign s_axis_tready = job_ready_i;

endmodule

`default_nettype wire

>>> rtl/etf_back.sv
// Iteration engine: square-and-update loop (StMul, StUpd) with result register on the output stream.
// Depends on etf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module etf_back import etf_pkg::*; #(
  parameter int unsigned CountW = CountWidth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     job_valid_i,
  output logic          job_ready_o,
  input  wire etf_job_t job_i,
  output logic          m_axis_tvalid,
  input  wire logic     m_axis_tready,
  output logic [79:0]   m_axis_tdata
);

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StUpd
  } state_e;

  state_e state_q;

  logic signed [CoordWidth-1:0] x_q, y_q, cr_q, ci_q;
  logic [LimitWidth-1:0]        limit_q;
  logic [CountW-1:0]            count_q;
  logic signed [MagWidth-1:0]   xx_q, yy_q, xy_q;

  logic [MagWidth-1:0]          mag;
  logic signed [MagWidth-1:0]   re2, sum_re, sum_im;
  logic signed [CoordWidth-1:0] nx, ny;
  logic                         fin, slot_free, escaped, out_load;
  logic [MagOutWidth-1:0]       mag_out;

  function automatic logic signed [CoordWidth-1:0] sat_coord(logic signed [MagWidth-1:0] v);
    logic ovf;
    ovf = (v[MagWidth-1:CoordWidth-1] != '0) && (v[MagWidth-1:CoordWidth-1] != '1);
    if (!ovf) begin
      sat_coord = v[CoordWidth-1:0];
    end else if (v[MagWidth-1]) begin
      sat_coord = {1'b1, {(CoordWidth-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(CoordWidth-1){1'b1}}};
    end
  endfunction

  always_comb begin
    mag     = $unsigned(xx_q) + $unsigned(yy_q);
    re2     = xx_q - yy_q;
    sum_re  = (re2 >>> CoordFracBits) + MagWidth'(cr_q);
    sum_im  = (xy_q >>> (CoordFracBits - 1)) + MagWidth'(ci_q);
    nx      = sat_coord(sum_re);
    ny      = sat_coord(sum_im);
    escaped = (mag >= MagFour);
    fin     = escaped || (32'(count_q) >= 32'(limit_q));
    mag_out = mag[MagWidth-1] ? '1 : mag[MagOutWidth-1:0];
  end

  assign slot_free   = !m_axis_tvalid || m_axis_tready;
  assign job_ready_o = (state_q == StIdle);
  assign out_load    = (state_q == StUpd) && fin && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {mag_out, escaped, 16'(count_q)};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          state_q <= StUpd;
        end
        StUpd: begin
          if (!fin) begin
            state_q <= StMul;
          end else if (slot_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          x_q     <= job_i.x;
          y_q     <= job_i.y;
          cr_q    <= job_i.cr;
          ci_q    <= job_i.ci;
          limit_q <= job_i.limit;
          count_q <= '0;
        end
      end
      StMul: begin
        xx_q <= x_q * x_q;
        yy_q <= y_q * y_q;
        xy_q <= x_q * y_q;
      end
      StUpd: begin
        if (!fin) begin
          x_q     <= nx;
          y_q     <= ny;
          count_q <= count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/escape_time_fractal_iterator_core.sv
// Top level of the escape-time fractal iterator (Mandelbrot / Julia).
// Depends on etf_pkg, etf_front, etf_queue and etf_back.
//
// Each input beat carries one point in signed Q4.28 and yields one output beat with the
// iteration count, the escaped flag and the final |z|^2 in unsigned Q7.56. Every step of
// z = z*z + c in the iteration engine is a pass through the three 32x32 multipliers
// (StMul) and then a pass of update and escape test (StUpd). A two-entry queue in front
// of the engine lets up to two further points be accepted while one is iterating, and the
// output register lets the engine take the next point while a finished result waits to be
// taken. Configuration is sampled as points enter.
`timescale 1ns / 1ps
`default_nettype none

module escape_time_fractal_iterator_core import etf_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidth
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [63:0]             s_axis_tdata,  // point_re, point_im
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [79:0]                  m_axis_tdata   // iteration_count, escaped, final_magnitude_sq
);

  localparam int unsigned JobWidth = $bits(etf_job_t);

  logic     front_valid, front_ready;
  etf_job_t front_job;
  logic     back_valid, back_ready;
  etf_job_t back_job;
  logic [JobWidth-1:0] queue_out;

  etf_front #(
    .CountW (COUNT_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .job_valid_o   (front_valid),
    .job_ready_i   (front_ready),
    .job_o         (front_job)
  );

  etf_queue #(
    .Width (JobWidth),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_out)
  );

  assign back_job = etf_job_t'(queue_out);

  etf_back #(
    .CountW (COUNT_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (back_valid),
    .job_ready_o   (back_ready),
    .job_i         (back_job),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> tb/fractal_result_checker.sv
// Checker for the escape-time fractal iterator: tracks the register writes, predicts each
// result beat from the point beats it sees and compares them field by field in order.
// Depends on etf_pkg; instantiated beside the block by tb.
`timescale 1ns / 1ps

module fractal_result_checker import etf_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  input  wire logic                    point_valid_i,
  input  wire logic                    point_ready_i,
  input  wire logic [63:0]             point_data_i,   // point_re, point_im
  input  wire logic                    result_valid_i,
  input  wire logic                    result_ready_i,
  input  wire logic [79:0]             result_data_i,  // iteration_count, escaped, final_magnitude_sq
  output int                           pending_o,
  output int                           fail_count_o
);

  localparam longint unsigned CountMax = (64'd1 << CountWidth) - 1;

  typedef struct packed {
    logic [MagOutWidth-1:0] magnitude_sq;
    logic                   escaped;
    logic [CountWidth-1:0]  count;
  } escape_result_t;

  logic                         mode_julia = 1'b0;
  logic signed [CoordWidth-1:0] const_re   = '0;
  logic signed [CoordWidth-1:0] const_im   = '0;
  logic [LimitWidth-1:0]        step_limit = IterLimitReset;
  escape_result_t               awaited_results[$];
  int                           mismatches = 0;

  function automatic longint signed clamp_coord(input longint signed v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic escape_result_t iterate_point(input logic [CoordWidth-1:0] pre,
                                                   input logic [CoordWidth-1:0] pim);
    longint signed       x, y, cr, ci, re2, xy;
    longint unsigned     limit, count;
    logic [MagWidth-1:0] mag;
    escape_result_t      res;
    limit = step_limit;
    if (limit > CountMax) limit = CountMax;
    if (mode_julia) begin
      x  = $signed(pre);
      y  = $signed(pim);
      cr = const_re;
      ci = const_im;
    end else begin
      x  = 0;
      y  = 0;
      cr = $signed(pre);
      ci = $signed(pim);
    end
    count = 0;
    mag   = x * x + y * y;
    while (mag < MagFour && count < limit) begin
      re2   = x * x - y * y;
      xy    = x * y;
      x     = clamp_coord((re2 >>> CoordFracBits) + cr);
      y     = clamp_coord((xy >>> (CoordFracBits - 1)) + ci);
      count = count + 1;
      mag   = x * x + y * y;
    end
    res.count        = CountWidth'(count);
    res.escaped      = (mag >= MagFour);
    res.magnitude_sq = mag[MagWidth-1] ? '1 : mag[MagOutWidth-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    escape_result_t got, want;
    if (!rst_ni) begin
      mode_julia = 1'b0;
      const_re   = '0;
      const_im   = '0;
      step_limit = IterLimitReset;
      awaited_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegJuliaMode: mode_julia = cfg_data_i[0];
          RegJuliaRe:   const_re   = cfg_data_i[CoordWidth-1:0];
          RegJuliaIm:   const_im   = cfg_data_i[CoordWidth-1:0];
          RegIterLimit: step_limit = cfg_data_i[LimitWidth-1:0];
          default: ;
        endcase
      end
      if (result_valid_i && result_ready_i) begin
        got = result_data_i;
        if (awaited_results.size() == 0) begin
          $error("result beat %h arrived with no point outstanding", result_data_i);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (got.count !== want.count) begin
            $error("iteration_count: expected %0d, got %0d", want.count, got.count);
            mismatches++;
          end
          if (got.escaped !== want.escaped) begin
            $error("escaped: expected %0d, got %0d", want.escaped, got.escaped);
            mismatches++;
          end
          if (got.magnitude_sq !== want.magnitude_sq) begin
            $error("final_magnitude_sq: expected %h, got %h", want.magnitude_sq,
                   got.magnitude_sq);
            mismatches++;
          end
        end
      end
      if (point_valid_i && point_ready_i) begin
        awaited_results.push_back(iterate_point(point_data_i[31:0], point_data_i[63:32]));
      end
    end
    pending_o    <= awaited_results.size();
    fail_count_o <= mismatches;
  end

endmodule

>>> tb/tb.sv
// Testbench top for escape_time_fractal_iterator_core: drives points and register writes
// with random idling, and gives the verdict from the counts of fractal_result_checker.
// Depends on etf_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb;
  import etf_pkg::*;

  localparam logic [31:0] CoordMin  = 32'h8000_0000;
  localparam logic [31:0] CoordMax  = 32'h7FFF_FFFF;
  localparam logic [31:0] One       = 32'h1000_0000;
  localparam logic [31:0] Two       = 32'h2000_0000;
  localparam logic [31:0] Quarter   = 32'h0400_0000;
  localparam logic [31:0] Half      = 32'h0800_0000;
  localparam logic [31:0] OneTenth  = 32'h0199_999A;
  localparam logic [31:0] ThreeTen  = 32'h04CC_CCCD;
  localparam logic [31:0] OneHalf3  = 32'h1800_0000;
  localparam logic [31:0] OneNine   = 32'h1E66_6666;
  localparam int unsigned PlaneSpan = 603979776;
  localparam int unsigned PhaseSize = 98;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index_i   = '0;
  logic [CfgDataWidth-1:0] cfg_data_i    = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic [63:0]             s_axis_tdata  = '0;
  logic                    m_axis_tready = 1'b0;
  wire logic               s_axis_tready;
  wire logic               m_axis_tvalid;
  wire logic [79:0]        m_axis_tdata;
  int                      pending_points;
  int                      fail_count;
  bit                      idle_on = 1'b1;

  escape_time_fractal_iterator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fractal_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .point_valid_i  (s_axis_tvalid),
    .point_ready_i  (s_axis_tready),
    .point_data_i   (s_axis_tdata),
    .result_valid_i (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .result_data_i  (m_axis_tdata),
    .pending_o      (pending_points),
    .fail_count_o   (fail_count)
  );

  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  function automatic logic [31:0] random_coord(input int unsigned span);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return CoordMin;
          1: return CoordMax;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endcase
  endfunction

  task automatic send_point(input logic [31:0] re, input logic [31:0] im);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_points != 0);
  endtask

  task automatic put_reg(input logic [CfgIdxWidth-1:0] idx,
                         input logic [CfgDataWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // Unused upper bits of the mode and limit registers are filled with noise.
  task automatic configure(input logic mode, input logic [31:0] re, input logic [31:0] im,
                           input logic [15:0] limit);
    logic [CfgDataWidth-1:0] noise;
    noise = $urandom;
    put_reg(RegJuliaMode, {noise[31:1], mode});
    put_reg(RegJuliaRe, re);
    put_reg(RegJuliaIm, im);
    noise = $urandom;
    put_reg(RegIterLimit, {noise[31:16], limit});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic        mode;
    logic [31:0] c_re, c_im;
    logic [15:0] limit;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: Mandelbrot with a limit of 256.
    send_point('0, '0);
    send_point(Two, '0);
    send_point(-Two, '0);
    send_point(CoordMax, CoordMax);
    send_point(CoordMin, CoordMin);
    send_point(Quarter, '0);
    send_point(-(3 * Quarter), OneTenth);
    send_point('0, One);
    send_point(ThreeTen, Half);
    send_point(-One, '0);
    wait_drained();

    // A limit of one lets a point escape on the very step that ends the run.
    configure(1'b0, CoordMax, CoordMin, 16'd1);
    send_point(Two, '0);
    send_point(One, One);
    send_point('0, '0);
    wait_drained();

    // Julia mode with no steps at all: only the start magnitude comes back.
    configure(1'b1, CoordMin, CoordMax, 16'd0);
    send_point('0, '0);
    send_point(CoordMin, CoordMin);
    send_point(OneHalf3, OneHalf3);
    send_point(CoordMax, '0);
    wait_drained();

    configure(1'b1, 32'hF333_3333, 32'h027E_F9DB, 16'hFFFF);
    send_point('0, '0);
    send_point(OneNine, '0);
    send_point(CoordMin, CoordMax);
    wait_drained();

    for (int phase = 0; phase < 9; phase++) begin
      idle_on = (phase < 8);
      mode    = phase[0];
      if ($urandom_range(0, 3) == 0) begin
        c_re = random_coord(PlaneSpan);
        c_im = random_coord(PlaneSpan);
      end else begin
        c_re = 32'($urandom_range(0, 2 * One)) - One;
        c_im = 32'($urandom_range(0, 2 * One)) - One;
      end
      case ($urandom_range(0, 5))
        0: limit = 16'($urandom_range(0, 8));
        1, 2, 3: limit = 16'($urandom_range(9, 64));
        4: limit = IterLimitReset;
        default: limit = 16'($urandom_range(65, 300));
      endcase
      configure(mode, c_re, c_im, limit);
      for (int n = 0; n < PhaseSize; n++) begin
        send_point(random_coord(PlaneSpan), random_coord(PlaneSpan));
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_points == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
